// ----- src/iat_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// iat_pkg
// Shared types, register indexes, reset values and the advance step table
// of the ignition advance timer.
// ---------------------------------------------------------------------------
package iat_pkg;

  localparam int unsigned PulsesPerRevDefault = 2;

  // register file
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 20;
  localparam logic [CfgIdxW-1:0] CFG_REV_LIMIT  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TDC_EXIT   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SLOW       = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_TDC_COIL   = 2'd3;

  localparam logic [19:0] RevLimitReset = 20'd12000;
  localparam logic [7:0]  TdcExitReset  = 8'd100;
  localparam logic [19:0] SlowReset     = 20'd100000;
  localparam logic [15:0] TdcCoilReset  = 16'd4000;

  typedef enum logic [1:0] {
    ACT_IGNORE      = 2'd0,
    ACT_TDC_SPARK   = 2'd1,
    ACT_TIMED_SPARK = 2'd2,
    ACT_REV_HOLD    = 2'd3
  } iat_action_e;

  typedef struct packed {
    iat_action_e  action;
    logic [15:0]  spark_delay_us;
    logic [28:0]  coil_off_us;
    logic         tdc_mode;
    logic [31:0]  period_us;
  } iat_result_t;

  // advance steps: first limit above the period selects the delay
  localparam int unsigned NumSteps = 25;

  localparam logic [31:0] StepLimit [NumSteps] = '{
    32'd12000,  32'd12500,  32'd13043,  32'd13636,  32'd14286,  32'd15000,
    32'd15789,  32'd16667,  32'd17647,  32'd18750,  32'd20000,  32'd21429,
    32'd23077,  32'd25000,  32'd27273,  32'd30000,  32'd33333,  32'd37500,
    32'd42857,  32'd50000,  32'd60000,  32'd75000,  32'd100000, 32'd150000,
    32'd300000
  };

  localparam logic [15:0] StepDelay [NumSteps] = '{
    16'd1393,  16'd1456,  16'd1523,  16'd1597,  16'd1678,  16'd1767,
    16'd1865,  16'd1974,  16'd2096,  16'd2233,  16'd2483,  16'd2668,
    16'd2881,  16'd3129,  16'd3423,  16'd3975,  16'd4504,  16'd5165,
    16'd6014,  16'd7147,  16'd8733,  16'd11233, 16'd15400, 16'd23733,
    16'd48733
  };

  typedef struct packed {
    logic        hit;
    logic [15:0] delay;
  } iat_step_t;

  // Parallel compares, lowest step wins; no hit above the last limit.
  function automatic iat_step_t step_lookup(input logic [31:0] period);
    iat_step_t res;
    res.hit   = 1'b0;
    res.delay = '0;
    for (int i = NumSteps - 1; i >= 0; i--) begin
      if (period < StepLimit[i]) begin
        res.hit   = 1'b1;
        res.delay = StepDelay[i];
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- src/iat_in_reg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// iat_in_reg
// Input register: captures one edge request and holds it until the core
// takes it.
// ---------------------------------------------------------------------------
module iat_in_reg import iat_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] time_us_i,
  input  wire logic        edge_rising_i,
  input  wire logic        take_i,
  output logic             item_valid_o,
  output logic [31:0]      item_time_o,
  output logic             item_rising_o
);

  logic        valid_q, valid_d;
  logic [31:0] time_q;
  logic        rising_q;

  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      time_q   <= time_us_i;
      rising_q <= edge_rising_i;
    end
  end

  assign item_valid_o  = valid_q;
  assign item_time_o   = time_q;
  assign item_rising_o = rising_q;

endmodule
`default_nettype wire

// ----- src/iat_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// iat_core
// Mode control, period measurement and advance lookup for one edge, with
// the engine state, the register file and the result register.
// ---------------------------------------------------------------------------
module iat_core import iat_pkg::*; #(
  parameter int unsigned PULSES_PER_REV = PulsesPerRevDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                item_valid_i,
  input  wire logic [31:0]         item_time_i,
  input  wire logic                item_rising_i,
  output logic                     take_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output iat_result_t              result_o
);

  localparam int unsigned PetalW = (PULSES_PER_REV > 1) ? $clog2(PULSES_PER_REV) : 1;
  localparam logic [PetalW:0] PetalWrap = (PetalW + 1)'(PULSES_PER_REV);

  // register file
  logic [19:0] rev_limit_q, slow_q;
  logic [7:0]  tdc_exit_q;
  logic [15:0] tdc_coil_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rev_limit_q <= RevLimitReset;
      tdc_exit_q  <= TdcExitReset;
      slow_q      <= SlowReset;
      tdc_coil_q  <= TdcCoilReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_REV_LIMIT: rev_limit_q <= cfg_wdata_i;
        CFG_TDC_EXIT:  tdc_exit_q  <= cfg_wdata_i[7:0];
        CFG_SLOW:      slow_q      <= cfg_wdata_i;
        CFG_TDC_COIL:  tdc_coil_q  <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // engine state
  logic              tdc_q, tdc_d;
  logic [7:0]        pulse_q, pulse_d;
  logic [PetalW-1:0] petal_q, petal_d;
  logic [31:0]       last_q, last_d;
  logic [31:0]       period_q, period_d;
  logic [15:0]       adv_q, adv_d;
  logic [28:0]       dwell_q, dwell_d;

  logic              out_valid_q;
  iat_result_t       res_q, res_d;

  logic              out_free;
  logic              act_edge;
  logic [8:0]        cnt;
  logic [PetalW:0]   petal_nx;
  logic [31:0]       span;
  iat_step_t         step;

  assign out_free = !out_valid_q || out_ready_i;
  assign take_o   = item_valid_i && out_free;

  assign act_edge = tdc_q ? !item_rising_i : item_rising_i;
  assign cnt      = {1'b0, pulse_q} + 9'd1;
  assign petal_nx = {1'b0, petal_q} + {{PetalW{1'b0}}, 1'b1};
  assign span     = item_time_i - last_q;
  assign step     = step_lookup(span);

  always_comb begin
    tdc_d    = tdc_q;
    pulse_d  = pulse_q;
    petal_d  = petal_q;
    last_d   = last_q;
    period_d = period_q;
    adv_d    = adv_q;
    dwell_d  = dwell_q;

    res_d.action         = ACT_IGNORE;
    res_d.spark_delay_us = '0;
    res_d.coil_off_us    = '0;

    if (act_edge) begin
      if (tdc_q) begin
        res_d.action      = ACT_TDC_SPARK;
        res_d.coil_off_us = {13'd0, tdc_coil_q};
        // leave TDC mode once the count passes the exit setting
        if (cnt > {1'b0, tdc_exit_q}) begin
          tdc_d   = 1'b0;
          pulse_d = '0;
        end else begin
          pulse_d = cnt[7:0];
        end
      end else if (period_q > {12'd0, rev_limit_q}) begin
        res_d.action         = ACT_TIMED_SPARK;
        res_d.spark_delay_us = adv_q;
        res_d.coil_off_us    = dwell_q;
      end else begin
        res_d.action = ACT_REV_HOLD;
      end

      // one full rotation completes every PULSES_PER_REV active edges
      if (petal_nx < PetalWrap) begin
        petal_d = petal_nx[PetalW-1:0];
      end else begin
        petal_d  = '0;
        period_d = span;
        last_d   = item_time_i;
        dwell_d  = span[31:3];
        if (span > {12'd0, slow_q}) begin
          tdc_d = 1'b1;
        end
        if (step.hit) begin
          adv_d = step.delay;
        end
      end
    end

    res_d.tdc_mode  = tdc_d;
    res_d.period_us = period_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tdc_q       <= 1'b1;
      pulse_q     <= '0;
      petal_q     <= '0;
      last_q      <= '0;
      period_q    <= '0;
      adv_q       <= '0;
      dwell_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take_o) begin
        tdc_q    <= tdc_d;
        pulse_q  <= pulse_d;
        petal_q  <= petal_d;
        last_q   <= last_d;
        period_q <= period_d;
        adv_q    <= adv_d;
        dwell_q  <= dwell_d;
      end
      if (out_free) begin
        out_valid_q <= item_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

endmodule
`default_nettype wire

// ----- src/ignition_advance_timer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ignition_advance_timer
// Ignition timing from timestamped crank-sensor edges.
//
// Each edge request (time_us_i, edge_rising_i) on the in_valid_i/in_ready_o
// channel yields exactly one result on out_valid_o/out_ready_i: the action,
// spark delay, coil-off time, mode after the edge and the latest period.
// A request accepted at a clock edge is registered in the input register,
// processed by the core and its result held in the result register, from
// which it is offered. One request per cycle is sustained while the
// receiver takes results; the limit is the state update in the core, which
// reads the state the previous request left behind.
// While the receiver stalls the result register holds its item, the input
// register still takes one more request, and in_ready_o drops only when
// both are full. Reset starts the block in TDC mode with zero period,
// delay and coil-off time and loads the register defaults. The user writes
// registers through cfg_we_i/cfg_idx_i/cfg_wdata_i while no request is in
// flight; the block itself does not enforce this.
// ---------------------------------------------------------------------------
module ignition_advance_timer import iat_pkg::*; #(
  parameter int unsigned PULSES_PER_REV = PulsesPerRevDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [31:0]         time_us_i,
  input  wire logic                edge_rising_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [1:0]               action_o,
  output logic [15:0]              spark_delay_us_o,
  output logic [28:0]              coil_off_us_o,
  output logic                     tdc_mode_o,
  output logic [31:0]              period_us_o
);

  logic        take;
  logic        item_valid;
  logic [31:0] item_time;
  logic        item_rising;
  iat_result_t result;

  iat_in_reg u_in_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .time_us_i     (time_us_i),
    .edge_rising_i (edge_rising_i),
    .take_i        (take),
    .item_valid_o  (item_valid),
    .item_time_o   (item_time),
    .item_rising_o (item_rising)
  );

  iat_core #(
    .PULSES_PER_REV (PULSES_PER_REV)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .item_valid_i  (item_valid),
    .item_time_i   (item_time),
    .item_rising_i (item_rising),
    .take_o        (take),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_o      (result)
  );

  assign action_o         = result.action;
  assign spark_delay_us_o = result.spark_delay_us;
  assign coil_off_us_o    = result.coil_off_us;
  assign tdc_mode_o       = result.tdc_mode;
  assign period_us_o      = result.period_us;

endmodule
`default_nettype wire

// ----- src/iat_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// iat_checker
// Port-level checks of the ignition advance timer, bound to the top level.
// ---------------------------------------------------------------------------
module iat_checker import iat_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [1:0]  action_o,
  input wire logic [15:0] spark_delay_us_o,
  input wire logic [28:0] coil_off_us_o,
  input wire logic        tdc_mode_o,
  input wire logic [31:0] period_us_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(action_o) &&
      $stable(spark_delay_us_o) && $stable(coil_off_us_o) &&
      $stable(tdc_mode_o) && $stable(period_us_o))
    else $error("result changed while stalled");

  // drop request ready only while a result waits
  a_ready_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  a_quiet_actions: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (action_o == ACT_IGNORE || action_o == ACT_REV_HOLD)
      |-> spark_delay_us_o == '0 && coil_off_us_o == '0)
    else $error("non-spark result carries timing");

  a_tdc_spark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o == ACT_TDC_SPARK
      |-> spark_delay_us_o == '0 && coil_off_us_o[28:16] == '0)
    else $error("TDC spark with delay or wide coil-off");

endmodule

bind ignition_advance_timer iat_checker u_iat_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .action_o         (action_o),
  .spark_delay_us_o (spark_delay_us_o),
  .coil_off_us_o    (coil_off_us_o),
  .tdc_mode_o       (tdc_mode_o),
  .period_us_o      (period_us_o)
);
`default_nettype wire

// ----- tb/tb_ignition_advance_timer.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_ignition_advance_timer
// Self-checking bench for the ignition advance timer. Edge requests are
// driven in bursts against a receiver that stalls on shifting patterns.
// Each accepted request runs through a local timing model, and every result
// is compared field by field in order. A short directed table opens the run,
// then register phases with mostly well-formed crank streams follow.
// ---------------------------------------------------------------------------
module tb_ignition_advance_timer;
  import iat_pkg::*;

  localparam int unsigned PETALS     = 2;
  localparam int unsigned CLK_HALF   = 5;
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned DIR_N      = 24;
  localparam int unsigned DIR_SPLIT  = 5;

  localparam logic [0:24][31:0] ADV_BOUND = {
    32'd12000,  32'd12500,  32'd13043,  32'd13636,  32'd14286,  32'd15000,
    32'd15789,  32'd16667,  32'd17647,  32'd18750,  32'd20000,  32'd21429,
    32'd23077,  32'd25000,  32'd27273,  32'd30000,  32'd33333,  32'd37500,
    32'd42857,  32'd50000,  32'd60000,  32'd75000,  32'd100000, 32'd150000,
    32'd300000
  };

  localparam logic [0:24][15:0] ADV_DELAY = {
    16'd1393,  16'd1456,  16'd1523,  16'd1597,  16'd1678,  16'd1767,
    16'd1865,  16'd1974,  16'd2096,  16'd2233,  16'd2483,  16'd2668,
    16'd2881,  16'd3129,  16'd3423,  16'd3975,  16'd4504,  16'd5165,
    16'd6014,  16'd7147,  16'd8733,  16'd11233, 16'd15400, 16'd23733,
    16'd48733
  };

  typedef struct packed {
    logic [31:0] t_us;
    logic        rising;
    logic        typed;
    iat_result_t res;
  } dir_row_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = CFG_REV_LIMIT;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic [31:0]         time_us_i   = '0;
  logic                edge_rising_i = 1'b0;
  logic                out_ready_i = 1'b0;
  logic                in_ready_o;
  logic                out_valid_o;
  logic [1:0]          action_o;
  logic [15:0]         spark_delay_us_o;
  logic [28:0]         coil_off_us_o;
  logic                tdc_mode_o;
  logic [31:0]         period_us_o;

  ignition_advance_timer #(
    .PULSES_PER_REV(PETALS)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .time_us_i       (time_us_i),
    .edge_rising_i   (edge_rising_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .action_o        (action_o),
    .spark_delay_us_o(spark_delay_us_o),
    .coil_off_us_o   (coil_off_us_o),
    .tdc_mode_o      (tdc_mode_o),
    .period_us_o     (period_us_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // timing model state and its copy of the registers
  logic        tdc_on    = 1'b1;
  logic [7:0]  tdc_cnt   = '0;
  logic [3:0]  petal     = '0;
  logic [31:0] rev_stamp = '0;
  logic [31:0] period    = '0;
  logic [15:0] adv_delay = '0;
  logic [28:0] dwell     = '0;
  logic [19:0] cfg_rev   = 20'd12000;
  logic [7:0]  cfg_exit  = 8'd100;
  logic [19:0] cfg_slow  = 20'd100000;
  logic [15:0] cfg_coil  = 16'd4000;

  iat_result_t timing_due[$];
  int          errors      = 0;
  int          idle_cycles = 0;
  int          burst_left  = 0;
  logic [31:0] stream_us   = '0;

  dir_row_t    dir_tab [DIR_N];

  function automatic logic [16:0] advance_for(input logic [31:0] p);
    for (int i = 0; i < 25; i++) begin
      if (p < ADV_BOUND[i]) return {1'b1, ADV_DELAY[i]};
    end
    return '0;
  endfunction

  task automatic take_period(input logic [31:0] t_us);
    logic [4:0]  nxt;
    logic [16:0] lk;
    nxt = {1'b0, petal} + 5'd1;
    if (nxt < PETALS) begin
      petal = nxt[3:0];
    end else begin
      petal     = '0;
      period    = t_us - rev_stamp;
      if (period > {12'b0, cfg_slow}) tdc_on = 1'b1;
      rev_stamp = t_us;
      dwell     = period[31:3];
      lk        = advance_for(period);
      // above the last step the old delay stays
      if (lk[16]) adv_delay = lk[15:0];
    end
  endtask

  task automatic compute_timing(input logic [31:0] t_us, input logic rising,
                                output iat_result_t res);
    logic [8:0] cnt;
    res        = '0;
    res.action = ACT_IGNORE;
    if (tdc_on) begin
      if (!rising) begin
        res.action      = ACT_TDC_SPARK;
        res.coil_off_us = {13'b0, cfg_coil};
        // compare without wrapping so 255 still exits
        cnt = {1'b0, tdc_cnt} + 9'd1;
        if (cnt > {1'b0, cfg_exit}) begin
          tdc_on = 1'b0;
          cnt    = '0;
        end
        tdc_cnt = cnt[7:0];
        take_period(t_us);
      end
    end else if (rising) begin
      if (period > {12'b0, cfg_rev}) begin
        res.action         = ACT_TIMED_SPARK;
        res.spark_delay_us = adv_delay;
        res.coil_off_us    = dwell;
      end else begin
        res.action = ACT_REV_HOLD;
      end
      take_period(t_us);
    end
    res.tdc_mode  = tdc_on;
    res.period_us = period;
  endtask

  function automatic dir_row_t dir_row(input logic [31:0] t_us, input logic rising,
                                       input logic typed, input iat_action_e act,
                                       input logic [15:0] dly, input logic [28:0] coil,
                                       input logic mode, input logic [31:0] per);
    dir_row_t row;
    row.t_us               = t_us;
    row.rising             = rising;
    row.typed              = typed;
    row.res.action         = act;
    row.res.spark_delay_us = dly;
    row.res.coil_off_us    = coil;
    row.res.tdc_mode       = mode;
    row.res.period_us      = per;
    return row;
  endfunction

  task automatic idle_gap(input int n);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // drop valid and hold until every outstanding result is back
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (timing_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
  endtask

  task automatic set_regs(input logic [19:0] rev, input logic [7:0] ext,
                          input logic [19:0] slow, input logic [15:0] coil);
    logic [11:0] junk_hi;
    logic [3:0]  junk_lo;
    junk_hi = 12'($urandom);
    junk_lo = 4'($urandom);
    write_reg(CFG_REV_LIMIT, rev);
    write_reg(CFG_TDC_EXIT, {junk_hi, ext});
    write_reg(CFG_SLOW, slow);
    write_reg(CFG_TDC_COIL, {junk_lo, coil});
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_rev  = rev;
    cfg_exit = ext;
    cfg_slow = slow;
    cfg_coil = coil;
  endtask

  task automatic send_edge(input logic [31:0] t_us, input logic rising, input logic typed,
                           input iat_result_t typed_res, output iat_action_e act);
    iat_result_t res;
    int          gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) idle_gap(gap);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    time_us_i     <= t_us;
    edge_rising_i <= rising;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    compute_timing(t_us, rising, res);
    timing_due.push_back(typed ? typed_res : res);
    act = res.action;
  endtask

  task automatic run_phase(input logic [19:0] rev, input logic [7:0] ext,
                           input logic [19:0] slow, input logic [15:0] coil,
                           input int quota);
    int          done;
    int          k;
    logic [31:0] tgt;
    logic [31:0] t_us;
    logic        rising;
    logic        want;
    iat_action_e act;
    done = 0;
    tgt  = 32'd20000;
    drain();
    set_regs(rev, ext, slow, coil);
    while (done < quota) begin
      k = $urandom_range(0, 99);
      if (k < 10) begin
        // noise: any timestamp, any polarity
        t_us      = $urandom;
        rising    = 1'($urandom_range(0, 1));
        stream_us = t_us;
      end else begin
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 9))
            0, 1, 2: tgt = ADV_BOUND[$urandom_range(0, 24)] - $urandom_range(0, 1);
            3, 4:    tgt = $urandom_range(1000, 320000);
            5:       tgt = {12'b0, cfg_rev} + $urandom_range(0, 2) - 1;
            6:       tgt = {12'b0, cfg_slow} + $urandom_range(0, 2) - 1;
            7:       tgt = $urandom_range(300000, 2000000);
            8:       tgt = $urandom_range(0, 12000);
            default: tgt = $urandom;
          endcase
        end
        want = ~tdc_on;
        if (k < 25) begin
          rising = ~want;
          t_us   = stream_us + $urandom_range(0, 5000);
        end else begin
          // split the target so the measured period lands on it exactly
          rising = want;
          if (petal == PETALS - 1) stream_us += tgt - (PETALS - 1) * (tgt / PETALS);
          else stream_us += tgt / PETALS;
          t_us = stream_us;
        end
      end
      send_edge(t_us, rising, 1'b0, '0, act);
      if (act != ACT_IGNORE) done++;
      if ($urandom_range(0, 49) == 0) drain();
    end
  endtask

  // receiver: stall pattern changes every so often
  int          rx_left = 0;
  logic [1:0]  rx_mode = 2'd0;
  logic [7:0]  rx_pat  = 8'h01;

  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= 2'($urandom_range(0, 3));
      rx_pat  <= 8'($urandom_range(1, 255));
      rx_left <= $urandom_range(50, 200);
    end else begin
      rx_left <= rx_left - 1;
      rx_pat  <= {rx_pat[6:0], rx_pat[7]};
    end
    case (rx_mode)
      2'd0:    out_ready_i <= 1'b1;
      2'd1:    out_ready_i <= 1'($urandom_range(0, 1));
      2'd2:    out_ready_i <= rx_pat[0];
      default: out_ready_i <= ($urandom_range(0, 5) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    iat_result_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (timing_due.size() == 0) begin
        $error("result with no request outstanding: action %0d", action_o);
        errors++;
      end else begin
        e = timing_due.pop_front();
        if (action_o !== e.action) begin
          $error("action: expected %0d, got %0d", e.action, action_o);
          errors++;
        end
        if (spark_delay_us_o !== e.spark_delay_us) begin
          $error("spark_delay_us: expected %0d, got %0d", e.spark_delay_us,
                 spark_delay_us_o);
          errors++;
        end
        if (coil_off_us_o !== e.coil_off_us) begin
          $error("coil_off_us: expected %0d, got %0d", e.coil_off_us, coil_off_us_o);
          errors++;
        end
        if (tdc_mode_o !== e.tdc_mode) begin
          $error("tdc_mode: expected %0d, got %0d", e.tdc_mode, tdc_mode_o);
          errors++;
        end
        if (period_us_o !== e.period_us) begin
          $error("period_us: expected %0d, got %0d", e.period_us, period_us_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    iat_action_e act;
    // reset defaults: TDC mode, falling edges fire at once
    dir_tab[0]  = dir_row(32'd100, 1'b1, 1'b1, ACT_IGNORE, 16'd0, 29'd0, 1'b1, 32'd0);
    dir_tab[1]  = dir_row(32'd200, 1'b0, 1'b1, ACT_TDC_SPARK, 16'd0, 29'd4000, 1'b1, 32'd0);
    dir_tab[2]  = dir_row(32'd5000, 1'b0, 1'b1, ACT_TDC_SPARK, 16'd0, 29'd4000, 1'b1,
                          32'd5000);
    dir_tab[3]  = dir_row(32'hFFFF_FFFF, 1'b0, 1'b0, ACT_IGNORE, '0, '0, 1'b0, '0);
    dir_tab[4]  = dir_row(32'h0000_0000, 1'b1, 1'b0, ACT_IGNORE, '0, '0, 1'b0, '0);
    // exit on first pulse; the wrapped period forces TDC right back
    dir_tab[5]  = dir_row(32'h0000_0100, 1'b0, 1'b0, ACT_IGNORE, '0, '0, 1'b0, '0);
    dir_tab[6]  = dir_row(32'h0000_2100, 1'b0, 1'b0, ACT_IGNORE, '0, '0, 1'b0, '0);
    dir_tab[7]  = dir_row(32'h0000_3000, 1'b0, 1'b0, ACT_IGNORE, '0, '0, 1'b0, '0);
    dir_tab[8]  = dir_row(32'h0000_4100, 1'b1, 1'b0, ACT_IGNORE, '0, '0, 1'b0, '0);
    dir_tab[9]  = dir_row(32'h0000_8100, 1'b1, 1'b0, ACT_IGNORE, '0, '0, 1'b0, '0);
    dir_tab[10] = dir_row(32'h0000_C100, 1'b1, 1'b0, ACT_IGNORE, '0, '0, 1'b0, '0);
    dir_tab[11] = dir_row(32'd129408, 1'b1, 1'b0, ACT_IGNORE, '0, '0, 1'b0, '0);
    dir_tab[12] = dir_row(32'd209408, 1'b1, 1'b0, ACT_IGNORE, '0, '0, 1'b0, '0);
    // slow period: delay kept, coil-off still updated
    dir_tab[13] = dir_row(32'd409408, 1'b1, 1'b0, ACT_IGNORE, '0, '0, 1'b0, '0);
    dir_tab[14] = dir_row(32'd609408, 1'b1, 1'b0, ACT_IGNORE, '0, '0, 1'b0, '0);
    // period above the slow limit forces TDC
    dir_tab[15] = dir_row(32'd1609408, 1'b1, 1'b0, ACT_IGNORE, '0, '0, 1'b0, '0);
    dir_tab[16] = dir_row(32'd2609408, 1'b1, 1'b0, ACT_IGNORE, '0, '0, 1'b0, '0);
    dir_tab[17] = dir_row(32'd2609500, 1'b1, 1'b0, ACT_IGNORE, '0, '0, 1'b0, '0);
    dir_tab[18] = dir_row(32'd2610000, 1'b0, 1'b0, ACT_IGNORE, '0, '0, 1'b0, '0);
    dir_tab[19] = dir_row(32'hFFFF_FF00, 1'b1, 1'b0, ACT_IGNORE, '0, '0, 1'b0, '0);
    dir_tab[20] = dir_row(32'h0000_0050, 1'b0, 1'b0, ACT_IGNORE, '0, '0, 1'b0, '0);
    // timestamp wrap, then a short period trips the rev limiter
    dir_tab[21] = dir_row(32'h0000_00A0, 1'b1, 1'b0, ACT_IGNORE, '0, '0, 1'b0, '0);
    dir_tab[22] = dir_row(32'h0000_0100, 1'b1, 1'b0, ACT_IGNORE, '0, '0, 1'b0, '0);
    dir_tab[23] = dir_row(32'h0000_0200, 1'b0, 1'b0, ACT_IGNORE, '0, '0, 1'b0, '0);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIR_N; i++) begin
      if (i == DIR_SPLIT) begin
        drain();
        set_regs(20'd1000, 8'd0, 20'hFFFFF, 16'hFFFF);
      end
      send_edge(dir_tab[i].t_us, dir_tab[i].rising, dir_tab[i].typed, dir_tab[i].res, act);
    end
    stream_us = 32'h0000_0200;

    run_phase(20'd0, 8'd0, 20'hFFFFF, 16'hFFFF, 70);
    run_phase(20'd12000, 8'd100, 20'd100000, 16'd4000, 150);
    run_phase(20'($urandom_range(0, 60000)), 8'($urandom_range(0, 7)),
              20'($urandom_range(50000, 1048575)), 16'($urandom), 65);
    run_phase(20'hFFFFF, 8'd255, 20'd0, 16'd0, 290);
    run_phase(20'($urandom), 8'($urandom_range(0, 15)), 20'($urandom), 16'($urandom), 45);
    run_phase(20'd0, 8'd3, 20'd1000000, 16'd1234, 40);

    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
